// ===== hw/rtl/arfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive rank/frequency model: shared types, constants and microcode
// Field widths, operation and condition codes, and the control-word table
// that sequences the frequency/mapping datapath.
// ----------------------------------------------------------------------------
package arfm_pkg;

   // Field and storage widths.
   localparam int CNT_W  = 9;
   localparam int SYM_W  = 8;
   localparam int FREQ_W = 17;
   localparam int SUM_W  = 25;
   localparam int LIM_W  = 17;

   localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

   // Step addresses of the microprogram.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_INIT        = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SUM         = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SUM_TAIL    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CHECK       = 4'd5;
   localparam logic [STEP_W-1:0] STEP_HALVE       = 4'd6;
   localparam logic [STEP_W-1:0] STEP_HALVE_TAIL  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SCAN_POS    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SCAN_FIRST  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_SCAN        = 4'd10;
   localparam logic [STEP_W-1:0] STEP_SWAP_READ   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_SWAP_WRITE  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SWAP_WRITE2 = 4'd13;
   localparam logic [STEP_W-1:0] STEP_FINISH      = 4'd14;

   // Datapath operations.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_WAIT       = 4'd1;
   localparam logic [OP_W-1:0] OP_INIT       = 4'd2;
   localparam logic [OP_W-1:0] OP_SUM        = 4'd3;
   localparam logic [OP_W-1:0] OP_SUM_TAIL   = 4'd4;
   localparam logic [OP_W-1:0] OP_HALVE      = 4'd5;
   localparam logic [OP_W-1:0] OP_HALVE_TAIL = 4'd6;
   localparam logic [OP_W-1:0] OP_READ_POS   = 4'd7;
   localparam logic [OP_W-1:0] OP_CAPTURE    = 4'd8;
   localparam logic [OP_W-1:0] OP_SCAN       = 4'd9;
   localparam logic [OP_W-1:0] OP_READ_LAST  = 4'd10;
   localparam logic [OP_W-1:0] OP_UPDATE     = 4'd11;
   localparam logic [OP_W-1:0] OP_UPDATE2    = 4'd12;
   localparam logic [OP_W-1:0] OP_FINISH     = 4'd13;

   // Jump conditions.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER       = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_ITEM     = 3'd1;
   localparam logic [COND_W-1:0] COND_CMD_INIT    = 3'd2;
   localparam logic [COND_W-1:0] COND_LAST        = 3'd3;
   localparam logic [COND_W-1:0] COND_UNDER_LIMIT = 3'd4;
   localparam logic [COND_W-1:0] COND_SCAN_END    = 3'd5;
   localparam logic [COND_W-1:0] COND_OUT_BUSY    = 3'd6;

   // Command codes.
   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_BUMP = 1'b1;

   // One control word: operation, jump condition, jump target, fall-through.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jump;
      logic [STEP_W-1:0] next;
   } ctrl_word_type;

   // Strobes towards the table memories.
   typedef struct packed {
      logic rd_en;
      logic freq_we;
      logic sym_we;
   } tbl_ctrl_type;

   // The microprogram itself.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:        w = '{OP_WAIT,       COND_NO_ITEM,     STEP_IDLE,       STEP_DISPATCH};
         STEP_DISPATCH:    w = '{OP_NONE,       COND_CMD_INIT,    STEP_INIT,       STEP_SUM};
         STEP_INIT:        w = '{OP_INIT,       COND_LAST,        STEP_FINISH,     STEP_INIT};
         STEP_SUM:         w = '{OP_SUM,        COND_LAST,        STEP_SUM_TAIL,   STEP_SUM};
         STEP_SUM_TAIL:    w = '{OP_SUM_TAIL,   COND_NEVER,       STEP_CHECK,      STEP_CHECK};
         STEP_CHECK:       w = '{OP_NONE,       COND_UNDER_LIMIT, STEP_SCAN_POS,   STEP_HALVE};
         STEP_HALVE:       w = '{OP_HALVE,      COND_LAST,        STEP_HALVE_TAIL, STEP_HALVE};
         STEP_HALVE_TAIL:  w = '{OP_HALVE_TAIL, COND_NEVER,       STEP_SCAN_POS,   STEP_SCAN_POS};
         STEP_SCAN_POS:    w = '{OP_READ_POS,   COND_NEVER,       STEP_SCAN_FIRST, STEP_SCAN_FIRST};
         STEP_SCAN_FIRST:  w = '{OP_CAPTURE,    COND_NEVER,       STEP_SCAN,       STEP_SCAN};
         STEP_SCAN:        w = '{OP_SCAN,       COND_SCAN_END,    STEP_SWAP_READ,  STEP_SCAN};
         STEP_SWAP_READ:   w = '{OP_READ_LAST,  COND_NEVER,       STEP_SWAP_WRITE, STEP_SWAP_WRITE};
         STEP_SWAP_WRITE:  w = '{OP_UPDATE,     COND_NEVER,       STEP_SWAP_WRITE2,
                               STEP_SWAP_WRITE2};
         STEP_SWAP_WRITE2: w = '{OP_UPDATE2,    COND_NEVER,       STEP_FINISH,     STEP_FINISH};
         STEP_FINISH:      w = '{OP_FINISH,     COND_OUT_BUSY,    STEP_FINISH,     STEP_IDLE};
         default:          w = '{OP_NONE,       COND_NEVER,       STEP_IDLE,       STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/adaptive_rank_frequency_model.sv =====
// Sequence: an init word rewrites all n entries in use; a bump word (n entries in use) makes
// one table pass to sum, one to halve if the sum is not under the limit, and a scan of the run.
// Throughput: one word at a time; the single read port of each table sets the pace.
// Reset: synchronous; after reset the sequencer loads MAX_ENTRIES table entries (at most 256)
// and accepts no word meanwhile; register writes are taken throughout.
// ----------------------------------------------------------------------------
// Adaptive rank/frequency model
// Keeps a frequency and a symbol mapping per entry for an entropy decoder and
// updates them under a microcoded sequencer driving a small datapath.
// ----------------------------------------------------------------------------
module adaptive_rank_frequency_model
   import arfm_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [7:0]         req_position,
   input  logic [LIM_W-1:0]   req_total_limit,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SYM_W-1:0]   rsp_mapped_symbol,
   output logic [7:0]         rsp_new_position,
   // Register write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_entry_count
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] COUNT_RESET = (MAX_ENTRIES < 256) ? CNT_W'(MAX_ENTRIES)
                                                                  : CNT_W'(256);

   // Sequencer and control state.
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  entry_count_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic              rd_pend_ff;
   logic              emit_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [CNT_W-1:0]  rd_addr_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic              cmd_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  last_ff;
   logic [FREQ_W-1:0] f_ff;
   logic [SYM_W-1:0]  sym_keep_ff;
   logic [SYM_W-1:0]  rsp_sym_ff;
   logic [7:0]        rsp_pos_ff;

   ctrl_word_type     ctrl;
   tbl_ctrl_type      tbl_ctrl;
   logic              accept;
   logic              out_busy;
   logic              cond_hit;
   logic              last_idx;
   logic              scan_end;
   logic [CNT_W-1:0]  count_clamped;
   logic [CNT_W-1:0]  pos_ext;
   logic [CNT_W-1:0]  pos_sat;
   logic [CNT_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  freq_wr_addr;
   logic [CNT_W-1:0]  sym_wr_addr;
   logic [FREQ_W-1:0] freq_wr_data;
   logic [SYM_W-1:0]  sym_wr_data;
   logic [FREQ_W-1:0] freq_rd_data;
   logic [SYM_W-1:0]  sym_rd_data;
   logic [FREQ_W:0]   halved_sum;
   logic [FREQ_W-1:0] halved;
   logic [FREQ_W-1:0] incremented;
   logic [CNT_W-1:0]  init_map;

   // Handshakes.
   assign accept    = req_valid && (step_ff == STEP_IDLE);
   assign req_stall = (step_ff != STEP_IDLE);
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // A finished word loads the response register; a held word stays until taken.
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall)
                         || ((ctrl.op == OP_FINISH) && emit_ff && !out_busy);

   // Fetch the control word of the current step.
   assign ctrl = ucode_rom(step_ff);

   // Entry count as applied by init, and the saturated bump position.
   always_comb begin
      if (entry_count_ff == '0) begin
         count_clamped = CNT_W'(1);
      end else if (entry_count_ff > MAX_CNT) begin
         count_clamped = MAX_CNT;
      end else begin
         count_clamped = entry_count_ff;
      end
   end
   assign pos_ext = CNT_W'(req_position);
   assign pos_sat = (pos_ext >= n_ff) ? (n_ff - 1'b1) : pos_ext;

   // Loop termination tests.
   assign last_idx = (idx_ff == (n_ff - 1'b1));
   assign scan_end = (rd_pend_ff && (freq_rd_data != f_ff)) || (idx_ff == n_ff);

   // Evaluate the jump condition and pick the next step.
   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:       cond_hit = 1'b0;
         COND_NO_ITEM:     cond_hit = !accept;
         COND_CMD_INIT:    cond_hit = (cmd_ff == CMD_INIT);
         COND_LAST:        cond_hit = last_idx;
         COND_UNDER_LIMIT: cond_hit = (acc_ff < SUM_W'(limit_ff));
         COND_SCAN_END:    cond_hit = scan_end;
         COND_OUT_BUSY:    cond_hit = emit_ff && out_busy;
         default:          cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? ctrl.jump : ctrl.next;
   end

   // Arithmetic on table words.
   assign halved_sum  = {1'b0, freq_rd_data} + 1'b1;
   assign halved      = halved_sum[FREQ_W:1];
   assign incremented = (f_ff == FREQ_MAX) ? f_ff : (f_ff + 1'b1);
   assign init_map    = n_ff - idx_ff - 1'b1;

   // Decode the operation into memory strobes, addresses and write data.
   always_comb begin
      tbl_ctrl     = '0;
      rd_addr      = idx_ff;
      freq_wr_addr = idx_ff;
      sym_wr_addr  = idx_ff;
      freq_wr_data = halved;
      sym_wr_data  = init_map[SYM_W-1:0];
      unique case (ctrl.op)
         OP_INIT: begin
            tbl_ctrl.freq_we = 1'b1;
            tbl_ctrl.sym_we  = 1'b1;
            freq_wr_data     = FREQ_W'(1);
         end
         OP_SUM: begin
            tbl_ctrl.rd_en = 1'b1;
         end
         OP_HALVE: begin
            tbl_ctrl.rd_en   = 1'b1;
            tbl_ctrl.freq_we = rd_pend_ff;
            freq_wr_addr     = rd_addr_ff;
         end
         OP_HALVE_TAIL: begin
            tbl_ctrl.freq_we = 1'b1;
            freq_wr_addr     = rd_addr_ff;
         end
         OP_READ_POS: begin
            tbl_ctrl.rd_en = 1'b1;
            rd_addr        = pos_ff;
         end
         OP_SCAN: begin
            tbl_ctrl.rd_en = !scan_end;
         end
         OP_READ_LAST: begin
            tbl_ctrl.rd_en = 1'b1;
            rd_addr        = last_ff;
         end
         OP_UPDATE: begin
            // Move the run's mapping down to the position; bump the run's end.
            tbl_ctrl.freq_we = 1'b1;
            tbl_ctrl.sym_we  = 1'b1;
            freq_wr_addr     = last_ff;
            freq_wr_data     = incremented;
            sym_wr_addr      = pos_ff;
            sym_wr_data      = sym_rd_data;
         end
         OP_UPDATE2: begin
            tbl_ctrl.sym_we = 1'b1;
            sym_wr_addr     = last_ff;
            sym_wr_data     = sym_keep_ff;
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= STEP_INIT;
         entry_count_ff <= CNT_W'(256);
         n_ff           <= COUNT_RESET;
         idx_ff         <= '0;
         rd_pend_ff     <= 1'b0;
         emit_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rd_pend_ff   <= tbl_ctrl.rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entry_count_ff <= csr_entry_count;
         end
         unique case (ctrl.op)
            OP_WAIT: begin
               if (accept) begin
                  emit_ff <= 1'b1;
                  idx_ff  <= '0;
                  if (req_cmd == CMD_INIT) begin
                     n_ff <= count_clamped;
                  end
               end
            end
            OP_INIT, OP_SUM, OP_HALVE: begin
               idx_ff <= idx_ff + 1'b1;
            end
            OP_SUM_TAIL: begin
               idx_ff <= '0;
            end
            OP_CAPTURE: begin
               idx_ff <= pos_ff + 1'b1;
            end
            OP_SCAN: begin
               if (!scan_end) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            OP_FINISH: begin
               if (!(emit_ff && out_busy)) begin
                  emit_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (tbl_ctrl.rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      unique case (ctrl.op)
         OP_WAIT: begin
            if (accept) begin
               cmd_ff      <= req_cmd;
               limit_ff    <= req_total_limit;
               pos_ff      <= pos_sat;
               last_ff     <= '0;
               sym_keep_ff <= '0;
               acc_ff      <= '0;
            end
         end
         OP_SUM: begin
            if (rd_pend_ff) begin
               acc_ff <= acc_ff + SUM_W'(freq_rd_data);
            end
         end
         OP_SUM_TAIL: begin
            acc_ff <= acc_ff + SUM_W'(freq_rd_data);
         end
         OP_READ_POS: begin
            last_ff <= pos_ff;
         end
         OP_CAPTURE: begin
            f_ff        <= freq_rd_data;
            sym_keep_ff <= sym_rd_data;
         end
         OP_SCAN: begin
            if (rd_pend_ff && (freq_rd_data == f_ff)) begin
               last_ff <= rd_addr_ff;
            end
         end
         OP_FINISH: begin
            if (emit_ff && !out_busy) begin
               rsp_sym_ff <= sym_keep_ff;
               rsp_pos_ff <= last_ff[7:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Frequency and mapping storage.
   arfm_tables #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_tables (
      .clock        (clock),
      .tbl_ctrl     (tbl_ctrl),
      .rd_addr      (rd_addr[ADDR_W-1:0]),
      .freq_wr_addr (freq_wr_addr[ADDR_W-1:0]),
      .freq_wr_data (freq_wr_data),
      .sym_wr_addr  (sym_wr_addr[ADDR_W-1:0]),
      .sym_wr_data  (sym_wr_data),
      .freq_rd_data (freq_rd_data),
      .sym_rd_data  (sym_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mapped_symbol = rsp_sym_ff;
   assign rsp_new_position  = rsp_pos_ff;

endmodule

// ===== hw/rtl/arfm_tables.sv =====
// ----------------------------------------------------------------------------
// Adaptive rank/frequency model: frequency and mapping tables
// Two single-port-write, single-port-read memories sharing one read address.
// Read data is registered and appears the cycle after the read strobe.
// ----------------------------------------------------------------------------
module arfm_tables
   import arfm_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic               clock,
   input  tbl_ctrl_type       tbl_ctrl,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic [ADDR_W-1:0]  freq_wr_addr,
   input  logic [FREQ_W-1:0]  freq_wr_data,
   input  logic [ADDR_W-1:0]  sym_wr_addr,
   input  logic [SYM_W-1:0]   sym_wr_data,
   output logic [FREQ_W-1:0]  freq_rd_data,
   output logic [SYM_W-1:0]   sym_rd_data
);

   logic [FREQ_W-1:0] freq_mem [MAX_ENTRIES];
   logic [SYM_W-1:0]  sym_mem  [MAX_ENTRIES];
   logic [FREQ_W-1:0] freq_rd_ff;
   logic [SYM_W-1:0]  sym_rd_ff;

   // Frequency table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (tbl_ctrl.freq_we) begin
         freq_mem[freq_wr_addr] <= freq_wr_data;
      end
      if (tbl_ctrl.rd_en) begin
         freq_rd_ff <= freq_mem[rd_addr];
      end
   end

   // Mapping table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (tbl_ctrl.sym_we) begin
         sym_mem[sym_wr_addr] <= sym_wr_data;
      end
      if (tbl_ctrl.rd_en) begin
         sym_rd_ff <= sym_mem[rd_addr];
      end
   end

   assign freq_rd_data = freq_rd_ff;
   assign sym_rd_data  = sym_rd_ff;

endmodule
